>>> hdl/mi4_pkg.sv
`timescale 1ns / 1ps
// Package for the 4x4 matrix inverse core: number formats, limits and helpers.
// Used by every other file of the block except mi4_ram; depends on nothing.
package mi4_pkg;

  localparam int ENTRY_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int THR_W      = 31;
  localparam int IDX_W      = 4;
  localparam int IW         = 63;
  localparam int MAG_W      = IW - 1;
  localparam int HALF_W     = 32;
  localparam int OPD_W      = 2 * HALF_W;
  localparam int PROD_W     = 2 * OPD_W;
  localparam int NUM_W      = MAG_W + FRAC_BITS + 2;
  localparam int REM_W      = MAG_W + 2;
  localparam int CNT_W      = $clog2(NUM_W + 1);
  localparam int Q_W        = ENTRY_BITS + 1;

  typedef logic signed [IW-1:0]         ival_t;
  typedef logic signed [ENTRY_BITS-1:0] entry_t;

  localparam ival_t INT_LIMIT = {2'b00, {(IW-2){1'b1}}};

  function automatic ival_t clamp(input logic signed [IW:0] v);
    ival_t r;
    if (v > $signed({1'b0, INT_LIMIT})) r = INT_LIMIT;
    else if (v < -$signed({1'b0, INT_LIMIT})) r = -INT_LIMIT;
    else r = v[IW-1:0];
    return r;
  endfunction

  function automatic ival_t sx(input entry_t e);
    return {{(IW-ENTRY_BITS){e[ENTRY_BITS-1]}}, e};
  endfunction

  function automatic logic [MAG_W-1:0] mag(input ival_t v);
    ival_t r;
    r = v[IW-1] ? -v : v;
    return r[MAG_W-1:0];
  endfunction

  // store address of 3x3 minor element k with row skip_r and column skip_c removed;
  // past the minor, row 0 entry of column skip_c
  function automatic logic [IDX_W-1:0] fetch_addr(input logic [3:0] k,
                                                  input logic [1:0] skip_r,
                                                  input logic [1:0] skip_c);
    logic [1:0] r;
    logic [1:0] c;
    r = 2'd0;
    c = skip_c;
    case (k)
      4'd0: begin r = 2'd0; c = 2'd0; end
      4'd1: begin r = 2'd0; c = 2'd1; end
      4'd2: begin r = 2'd0; c = 2'd2; end
      4'd3: begin r = 2'd1; c = 2'd0; end
      4'd4: begin r = 2'd1; c = 2'd1; end
      4'd5: begin r = 2'd1; c = 2'd2; end
      4'd6: begin r = 2'd2; c = 2'd0; end
      4'd7: begin r = 2'd2; c = 2'd1; end
      4'd8: begin r = 2'd2; c = 2'd2; end
      default: begin r = 2'd0; c = skip_c; end
    endcase
    if (k < 4'd9) begin
      if (r >= skip_r) r = r + 2'd1;
      if (c >= skip_c) c = c + 2'd1;
    end
    return {r, c};
  endfunction

endpackage

>>> hdl/mi4_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for matrix entries and inverse results.
// Depends on mi4_pkg.
interface mi4_entry_if;
  logic                               valid;
  logic                               ready;
  logic signed [mi4_pkg::ENTRY_BITS-1:0] entry_value;
  logic [mi4_pkg::IDX_W-1:0]          entry_index;
  logic                               go;
  modport source(output valid, entry_value, entry_index, go, input ready);
  modport sink(input valid, entry_value, entry_index, go, output ready);
endinterface

interface mi4_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [mi4_pkg::ENTRY_BITS-1:0] inverse_value;
  logic [mi4_pkg::IDX_W-1:0]          out_index;
  logic                               singular;
  logic                               last_of_run;
  modport source(output valid, inverse_value, out_index, singular, last_of_run, input ready);
  modport sink(input valid, inverse_value, out_index, singular, last_of_run, output ready);
endinterface

>>> hdl/mi4_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mi4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/mi4_mul.sv
`timescale 1ns / 1ps
// Shared fixed-point multiplier: four 32x32 partial products, then round and saturate.
// Depends on mi4_pkg.
module mi4_mul (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mi4_pkg::ival_t a,
  input  mi4_pkg::ival_t b,
  output mi4_pkg::ival_t p,
  output logic           done
);
  logic                        busy;
  logic                        fin;
  logic [1:0]                  cnt;
  logic                        neg;
  logic [mi4_pkg::OPD_W-1:0]   ma;
  logic [mi4_pkg::OPD_W-1:0]   mb;
  logic [mi4_pkg::PROD_W-1:0]  acc;
  logic [mi4_pkg::HALF_W-1:0]  ah;
  logic [mi4_pkg::HALF_W-1:0]  bh;
  logic [mi4_pkg::OPD_W-1:0]   pp;
  logic [mi4_pkg::PROD_W-1:0]  pp_sh;
  logic [mi4_pkg::PROD_W-1:0]  rs;
  logic [mi4_pkg::PROD_W-1:0]  rl;
  mi4_pkg::ival_t              r;

  always_comb begin
    ah = cnt[1] ? ma[mi4_pkg::OPD_W-1:mi4_pkg::HALF_W] : ma[mi4_pkg::HALF_W-1:0];
    bh = cnt[0] ? mb[mi4_pkg::OPD_W-1:mi4_pkg::HALF_W] : mb[mi4_pkg::HALF_W-1:0];
    pp = mi4_pkg::OPD_W'(ah) * mi4_pkg::OPD_W'(bh);
    case (cnt)
      2'd0:    pp_sh = mi4_pkg::PROD_W'(pp);
      2'd3:    pp_sh = mi4_pkg::PROD_W'(pp) << (2 * mi4_pkg::HALF_W);
      default: pp_sh = mi4_pkg::PROD_W'(pp) << mi4_pkg::HALF_W;
    endcase
    rs = acc + (mi4_pkg::PROD_W'(1) << (mi4_pkg::FRAC_BITS - 1));
    rl = rs >> mi4_pkg::FRAC_BITS;
    r  = (rl > mi4_pkg::PROD_W'(mi4_pkg::INT_LIMIT)) ? mi4_pkg::INT_LIMIT
                                                     : rl[mi4_pkg::IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
        acc  <= '0;
        neg  <= a[mi4_pkg::IW-1] ^ b[mi4_pkg::IW-1];
        ma   <= mi4_pkg::OPD_W'(mi4_pkg::mag(a));
        mb   <= mi4_pkg::OPD_W'(mi4_pkg::mag(b));
      end else if (busy) begin
        acc <= acc + pp_sh;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        p    <= neg ? -r : r;
      end
    end
  end
endmodule

>>> hdl/mi4_div.sv
`timescale 1ns / 1ps
// Shared restoring divider: adj * 2^F / det, one quotient bit per cycle,
// rounded half away from zero and saturated to the entry range. Depends on mi4_pkg.
module mi4_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  mi4_pkg::ival_t                      a,
  input  mi4_pkg::ival_t                      b,
  output logic signed [mi4_pkg::ENTRY_BITS-1:0] q_out,
  output logic                                done
);
  logic                       busy;
  logic                       fin;
  logic [mi4_pkg::CNT_W-1:0]  cnt;
  logic                       neg;
  logic                       ovf;
  logic [mi4_pkg::REM_W-1:0]  dv;
  logic [mi4_pkg::NUM_W-1:0]  num;
  logic [mi4_pkg::REM_W-1:0]  rem;
  logic [mi4_pkg::Q_W-1:0]    q;
  logic [mi4_pkg::REM_W-1:0]  rs;
  logic                       ge;
  logic [mi4_pkg::Q_W-1:0]    lim;
  logic [mi4_pkg::Q_W-1:0]    qq;
  logic [mi4_pkg::Q_W-1:0]    res;

  always_comb begin
    rs  = {rem[mi4_pkg::REM_W-2:0], num[mi4_pkg::NUM_W-1]};
    ge  = (rs >= dv);
    lim = (mi4_pkg::Q_W'(1) << (mi4_pkg::ENTRY_BITS - 1)) - (neg ? '0 : mi4_pkg::Q_W'(1));
    qq  = (ovf || q > lim) ? lim : q;
    res = neg ? -qq : qq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= mi4_pkg::CNT_W'(mi4_pkg::NUM_W);
        neg  <= a[mi4_pkg::IW-1] ^ b[mi4_pkg::IW-1];
        dv   <= {1'b0, mi4_pkg::mag(b), 1'b0};
        num  <= (mi4_pkg::NUM_W'(mi4_pkg::mag(a)) << (mi4_pkg::FRAC_BITS + 1))
                + mi4_pkg::NUM_W'(mi4_pkg::mag(b));
        rem  <= '0;
        q    <= '0;
        ovf  <= 1'b0;
      end else if (busy) begin
        rem <= ge ? rs - dv : rs;
        q   <= {q[mi4_pkg::Q_W-2:0], ge};
        ovf <= ovf | q[mi4_pkg::Q_W-1];
        num <= num << 1;
        cnt <= cnt - mi4_pkg::CNT_W'(1);
        if (cnt == mi4_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin   <= 1'b0;
        done  <= 1'b1;
        q_out <= res[mi4_pkg::ENTRY_BITS-1:0];
      end
    end
  end
endmodule

>>> hdl/matrix_inverse_4x4_core.sv
`timescale 1ns / 1ps
// 4x4 matrix inverse by adjugate, Q16.16. A request without go is only stored.
// A go request computes the cofactor products on one shared multiplier, fetching
// each minor from the matrix store first, then runs 16 divisions on one shared
// divider; a singular matrix gives one result instead.
// Entry ready only while idle. Synchronous active-high reset: threshold returns to 1,
// control clears, matrix store holds garbage until written.
module matrix_inverse_4x4_core (
  input  logic                        clk,
  input  logic                        rst,
  mi4_entry_if.sink                   entry,
  mi4_result_if.source                result,
  input  logic                        cfg_we,
  input  logic [mi4_pkg::THR_W-1:0]   cfg_wdata
);
  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_FETCH     = 8'b0000_0010,
    S_MUL_START = 8'b0000_0100,
    S_MUL_WAIT  = 8'b0000_1000,
    S_DIV_RD    = 8'b0001_0000,
    S_DIV_START = 8'b0010_0000,
    S_DIV_WAIT  = 8'b0100_0000,
    S_EMIT      = 8'b1000_0000
  } state_t;

  state_t                      state;
  logic [mi4_pkg::THR_W-1:0]   thr;
  logic [3:0]                  cof;
  logic [3:0]                  k;
  logic [3:0]                  km1;
  logic [3:0]                  op;
  logic [3:0]                  oi;
  mi4_pkg::entry_t             s [9];
  mi4_pkg::entry_t             e0;
  mi4_pkg::ival_t              t;
  mi4_pkg::ival_t              d;
  mi4_pkg::ival_t              acc;
  mi4_pkg::ival_t              cofr;
  mi4_pkg::ival_t              det;
  logic                        sing;

  logic                        ovalid;
  mi4_pkg::entry_t             oval;
  logic [mi4_pkg::IDX_W-1:0]   oidx;
  logic                        osing;
  logic                        olast;

  logic                        st_we;
  logic [mi4_pkg::IDX_W-1:0]   st_raddr;
  logic [mi4_pkg::ENTRY_BITS-1:0] st_rdata;
  logic                        adj_we;
  mi4_pkg::ival_t              adj_rdata;

  logic                        mul_start;
  mi4_pkg::ival_t              mul_a;
  mi4_pkg::ival_t              mul_b;
  mi4_pkg::ival_t              mul_p;
  logic                        mul_done;
  logic                        div_start;
  mi4_pkg::entry_t             div_q;
  logic                        div_done;

  mi4_pkg::ival_t              sum8;
  mi4_pkg::ival_t              cof_val;
  mi4_pkg::ival_t              det_next;
  logic                        out_free;

  assign entry.ready  = (state == S_IDLE);
  assign st_we        = entry.valid & entry.ready;
  assign st_raddr     = mi4_pkg::fetch_addr(k, cof[3:2], cof[1:0]);
  assign km1          = k - 4'd1;
  assign out_free     = !ovalid || result.ready;
  assign adj_we       = (state == S_MUL_WAIT) && mul_done && (op == 4'd8);
  assign mul_start    = (state == S_MUL_START);
  assign div_start    = (state == S_DIV_START);

  assign result.valid         = ovalid;
  assign result.inverse_value = oval;
  assign result.out_index     = oidx;
  assign result.singular      = osing;
  assign result.last_of_run   = olast;

  always_comb begin
    sum8     = mi4_pkg::clamp({acc[mi4_pkg::IW-1], acc} + {mul_p[mi4_pkg::IW-1], mul_p});
    cof_val  = (cof[2] ^ cof[0]) ? -sum8 : sum8;
    det_next = mi4_pkg::clamp({det[mi4_pkg::IW-1], det} + {mul_p[mi4_pkg::IW-1], mul_p});
    case (op)
      4'd0:    begin mul_a = mi4_pkg::sx(s[4]); mul_b = mi4_pkg::sx(s[8]); end
      4'd1:    begin mul_a = mi4_pkg::sx(s[5]); mul_b = mi4_pkg::sx(s[7]); end
      4'd2:    begin mul_a = mi4_pkg::sx(s[0]); mul_b = d; end
      4'd3:    begin mul_a = mi4_pkg::sx(s[3]); mul_b = mi4_pkg::sx(s[8]); end
      4'd4:    begin mul_a = mi4_pkg::sx(s[5]); mul_b = mi4_pkg::sx(s[6]); end
      4'd5:    begin mul_a = mi4_pkg::sx(s[1]); mul_b = d; end
      4'd6:    begin mul_a = mi4_pkg::sx(s[3]); mul_b = mi4_pkg::sx(s[7]); end
      4'd7:    begin mul_a = mi4_pkg::sx(s[4]); mul_b = mi4_pkg::sx(s[6]); end
      4'd8:    begin mul_a = mi4_pkg::sx(s[2]); mul_b = d; end
      default: begin mul_a = mi4_pkg::sx(e0);   mul_b = cofr; end
    endcase
  end

  mi4_ram #(.WIDTH(mi4_pkg::ENTRY_BITS), .DEPTH(16)) u_store (
    .clk(clk), .we(st_we), .waddr(entry.entry_index), .wdata(entry.entry_value),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  mi4_ram #(.WIDTH(mi4_pkg::IW), .DEPTH(16)) u_adj (
    .clk(clk), .we(adj_we), .waddr({cof[1:0], cof[3:2]}), .wdata(cof_val),
    .raddr(oi), .rdata(adj_rdata)
  );

  mi4_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .p(mul_p), .done(mul_done)
  );

  mi4_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .a(adj_rdata), .b(det),
    .q_out(div_q), .done(div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      thr    <= mi4_pkg::THR_W'(1);
      ovalid <= 1'b0;
      cof    <= '0;
      k      <= '0;
      op     <= '0;
      oi     <= '0;
    end else begin
      if (cfg_we) thr <= cfg_wdata;
      if (ovalid && result.ready && state != S_EMIT) ovalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (st_we && entry.go) begin
            cof   <= '0;
            k     <= '0;
            det   <= '0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (k != 4'd0) begin
            if (km1 == 4'd9) e0 <= st_rdata;
            else s[km1] <= st_rdata;
          end
          if (k == 4'd10) begin
            op    <= '0;
            state <= S_MUL_START;
          end
          k <= k + 4'd1;
        end
        S_MUL_START: begin
          state <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mul_done) begin
            op    <= op + 4'd1;
            state <= S_MUL_START;
            case (op)
              4'd0, 4'd3, 4'd6: t <= mul_p;
              4'd1, 4'd4, 4'd7:
                d <= mi4_pkg::clamp({t[mi4_pkg::IW-1], t} - {mul_p[mi4_pkg::IW-1], mul_p});
              4'd2: acc <= mul_p;
              4'd5:
                acc <= mi4_pkg::clamp({acc[mi4_pkg::IW-1], acc}
                                      - {mul_p[mi4_pkg::IW-1], mul_p});
              4'd8: begin
                cofr <= cof_val;
                if (cof[3:2] != 2'd0) begin
                  k <= '0;
                  if (cof == 4'd15) begin
                    oi    <= '0;
                    sing  <= (det == '0) || (mi4_pkg::mag(det) < mi4_pkg::MAG_W'(thr));
                    state <= ((det == '0) || (mi4_pkg::mag(det) < mi4_pkg::MAG_W'(thr)))
                             ? S_EMIT : S_DIV_RD;
                  end else begin
                    cof   <= cof + 4'd1;
                    state <= S_FETCH;
                  end
                end
              end
              default: begin
                det   <= det_next;
                cof   <= cof + 4'd1;
                k     <= '0;
                state <= S_FETCH;
              end
            endcase
          end
        end
        S_DIV_RD: begin
          state <= S_DIV_START;
        end
        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            ovalid <= 1'b1;
            if (sing) begin
              oval  <= '0;
              oidx  <= '0;
              osing <= 1'b1;
              olast <= 1'b1;
              state <= S_IDLE;
            end else begin
              oval  <= div_q;
              oidx  <= oi;
              osing <= 1'b0;
              olast <= (oi == 4'd15);
              oi    <= oi + 4'd1;
              state <= (oi == 4'd15) ? S_IDLE : S_DIV_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_sing_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.singular |-> result.last_of_run && result.out_index == '0)
    else $error("singular result not alone");

  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_MUL_WAIT)
    else $error("multiplier result outside wait state");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV_WAIT)
    else $error("divider result outside wait state");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    ovalid && !result.ready |=> ovalid && $stable(oval) && $stable(oidx))
    else $error("stalled result changed");

endmodule
